// ----- rtl/core/ael_pkg.sv -----
// Types, constants and byte-class helpers for the arithmetic expression lexer.
package ael_pkg;

	localparam int MANT_BITS = 48;
	localparam int MAG_BITS = MANT_BITS - 1;
	localparam int TOK_BITS = 9;
	localparam int LEN_BITS = 5;
	localparam int FRAC_BITS = 4;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FILL_BITS = PTR_BITS + 1;

	localparam logic [MAG_BITS-1:0] MAG_MAX = '1;
	localparam logic [TOK_BITS-1:0] TOKEN_LIMIT = 9'd256;
	localparam logic [LEN_BITS-1:0] NAME_CHAR_LIMIT = 5'd30;
	localparam logic [FRAC_BITS-1:0] FRACTION_DIGIT_LIMIT = 4'd15;

	localparam logic [7:0] BYTE_SPACE = 8'h20;
	localparam logic [7:0] BYTE_POINT = 8'h2E;
	localparam logic [7:0] BYTE_PLUS = 8'h2B;
	localparam logic [7:0] BYTE_MINUS = 8'h2D;
	localparam logic [7:0] BYTE_STAR = 8'h2A;
	localparam logic [7:0] BYTE_SLASH = 8'h2F;
	localparam logic [7:0] BYTE_CARET = 8'h5E;
	localparam logic [7:0] BYTE_LPAREN = 8'h28;
	localparam logic [7:0] BYTE_RPAREN = 8'h29;
	localparam logic [7:0] BYTE_UNDERSCORE = 8'h5F;
	localparam logic [7:0] BYTE_SQ_LEAD = 8'hC2;
	localparam logic [7:0] BYTE_SQ_TAIL = 8'hB2;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_INT,
		MODE_FRAC,
		MODE_FRAC_DROP,
		MODE_IDENT,
		MODE_MINUS,
		MODE_SQ_LEAD,
		MODE_SKIP
	} mode_t;

	typedef enum logic [2:0] {
		KIND_NUMBER,
		KIND_OPERATOR,
		KIND_LPAREN,
		KIND_RPAREN,
		KIND_IDENT_CHAR,
		KIND_IDENT_END,
		KIND_DONE,
		KIND_ERROR
	} kind_t;

	typedef enum logic [2:0] {
		OP_PLUS,
		OP_MINUS,
		OP_TIMES,
		OP_DIVIDE,
		OP_POWER,
		OP_SQUARE
	} op_t;

	typedef struct packed {
		kind_t kind;
		op_t op;
		logic [MANT_BITS-1:0] mant;
		logic [FRAC_BITS-1:0] frac;
		logic sat;
		logic [7:0] ch;
		logic [TOK_BITS-1:0] tokens;
	} res_t;

	typedef struct packed {
		res_t res;
		logic last;
	} entry_t;

	typedef struct packed {
		mode_t mode;
		logic op_ctx;
		logic [TOK_BITS-1:0] total;
		logic [MAG_BITS-1:0] acc;
		logic [FRAC_BITS-1:0] frac;
		logic neg;
		logic clamp;
		logic [LEN_BITS-1:0] len;
	} lex_state_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_upper(input logic [7:0] b);
		return (b >= 8'h41) && (b <= 8'h5A);
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return is_upper(b) || ((b >= 8'h61) && (b <= 8'h7A));
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return is_upper(b) ? (b | 8'h20) : b;
	endfunction

	function automatic logic is_op_byte(input logic [7:0] b);
		return (b == BYTE_PLUS) || (b == BYTE_MINUS) || (b == BYTE_STAR) ||
			(b == BYTE_SLASH) || (b == BYTE_CARET);
	endfunction

	function automatic op_t op_of(input logic [7:0] b);
		op_t o;
		o = OP_PLUS;
		unique case (b)
			BYTE_MINUS: o = OP_MINUS;
			BYTE_STAR: o = OP_TIMES;
			BYTE_SLASH: o = OP_DIVIDE;
			BYTE_CARET: o = OP_POWER;
			default: o = OP_PLUS;
		endcase
		return o;
	endfunction

	function automatic lex_state_t clear_state();
		lex_state_t s;
		s = '0;
		s.mode = MODE_IDLE;
		s.op_ctx = 1'b1;
		return s;
	endfunction

endpackage

// ----- rtl/core/arith_expression_lexer.sv -----
// A result is queued when its byte is accepted; the output presents the queue head.
// Throughput: one byte per cycle while in_stall is low; each byte yields up to two results
// and, while out_stall is low, the output drains one result per cycle through a four-entry
// result queue. The input stalls while fewer than two queue entries are free.
// Reset (arst_n low, asynchronous) clears the lexer state and empties the queue.
// An end marker also returns the lexer state to its reset values.
module arith_expression_lexer import ael_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           byte_in,
	input  logic                 end_mark,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           kind,
	output logic [2:0]           op_code,
	output logic signed [47:0]   mantissa,
	output logic [3:0]           frac_count,
	output logic                 saturated,
	output logic [7:0]           ident_char,
	output logic [8:0]           tokens_seen,
	output logic                 last
);

	lex_state_t st_q, nx;
	entry_t fifo_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0] wptr_q, rptr_q;
	logic [FILL_BITS-1:0] fill_q;

	logic in_acc, out_acc;
	logic pre_v, main_v;
	res_t pre_r, main_r;
	logic [3:0] dig;
	logic [MAG_BITS+3:0] acc_x10;
	logic fits, full;
	logic [MANT_BITS-1:0] close_mant;
	entry_t head;
	logic [1:0] push_n;

	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = fill_q > FILL_BITS'(FIFO_DEPTH - 2);
	assign out_valid = fill_q != '0;

	assign dig = byte_in[3:0];
	assign acc_x10 = {1'b0, st_q.acc, 3'b000} + {3'b000, st_q.acc, 1'b0} +
		{{MAG_BITS{1'b0}}, dig};
	assign fits = acc_x10 <= {4'b0000, MAG_MAX};
	assign full = st_q.total >= TOKEN_LIMIT;
	assign close_mant = st_q.neg ? (MANT_BITS'(0) - {1'b0, st_q.acc}) : {1'b0, st_q.acc};

	always_comb begin
		logic do_start;
		logic do_begin;
		logic begin_neg;
		nx = st_q;
		pre_v = 1'b0;
		main_v = 1'b0;
		pre_r = '0;
		main_r = '0;
		do_start = 1'b0;
		do_begin = 1'b0;
		begin_neg = 1'b0;
		pre_r.kind = KIND_NUMBER;
		pre_r.mant = close_mant;
		pre_r.frac = st_q.frac;
		pre_r.sat = st_q.clamp;
		pre_r.tokens = st_q.total;
		if (end_mark) begin
			main_v = 1'b1;
			main_r.kind = KIND_DONE;
			unique case (st_q.mode)
				MODE_SKIP: main_v = 1'b0;
				MODE_MINUS, MODE_SQ_LEAD: main_r.kind = KIND_ERROR;
				MODE_INT, MODE_FRAC, MODE_FRAC_DROP: pre_v = 1'b1;
				MODE_IDENT: begin
					pre_v = 1'b1;
					pre_r = '0;
					pre_r.kind = KIND_IDENT_END;
					pre_r.tokens = st_q.total;
				end
				default: ;
			endcase
			nx = clear_state();
		end else begin
			unique case (st_q.mode)
				MODE_SKIP: ;
				MODE_MINUS: begin
					if (is_digit(byte_in) || byte_in == BYTE_POINT) begin
						do_begin = 1'b1;
						begin_neg = 1'b1;
					end else begin
						main_v = 1'b1;
						main_r.kind = KIND_ERROR;
						nx.mode = MODE_SKIP;
					end
				end
				MODE_SQ_LEAD: begin
					main_v = 1'b1;
					if (byte_in != BYTE_SQ_TAIL || full) begin
						main_r.kind = KIND_ERROR;
						nx.mode = MODE_SKIP;
					end else begin
						main_r.kind = KIND_OPERATOR;
						main_r.op = OP_SQUARE;
						nx.mode = MODE_IDLE;
						nx.total = st_q.total + 1'b1;
						nx.op_ctx = 1'b0;
					end
				end
				MODE_INT: begin
					if (is_digit(byte_in)) begin
						if (!fits) begin
							nx.acc = MAG_MAX;
							nx.clamp = 1'b1;
						end else begin
							nx.acc = acc_x10[MAG_BITS-1:0];
						end
					end else if (byte_in == BYTE_POINT) begin
						nx.mode = st_q.clamp ? MODE_FRAC_DROP : MODE_FRAC;
					end else begin
						pre_v = 1'b1;
						do_start = 1'b1;
					end
				end
				MODE_FRAC: begin
					if (is_digit(byte_in)) begin
						if (st_q.frac < FRACTION_DIGIT_LIMIT && fits) begin
							nx.acc = acc_x10[MAG_BITS-1:0];
							nx.frac = st_q.frac + 1'b1;
						end else begin
							nx.mode = MODE_FRAC_DROP;
						end
					end else begin
						pre_v = 1'b1;
						do_start = 1'b1;
					end
				end
				MODE_FRAC_DROP: begin
					if (!is_digit(byte_in)) begin
						pre_v = 1'b1;
						do_start = 1'b1;
					end
				end
				MODE_IDENT: begin
					if (is_alpha(byte_in) || is_digit(byte_in) || byte_in == BYTE_UNDERSCORE) begin
						if (st_q.len < NAME_CHAR_LIMIT) begin
							main_v = 1'b1;
							main_r.kind = KIND_IDENT_CHAR;
							main_r.ch = to_lower(byte_in);
							nx.len = st_q.len + 1'b1;
						end
					end else begin
						pre_v = 1'b1;
						pre_r = '0;
						pre_r.kind = KIND_IDENT_END;
						pre_r.tokens = st_q.total;
						do_start = 1'b1;
					end
				end
				default: do_start = 1'b1;
			endcase
		end

		if (do_start) begin
			nx.mode = MODE_IDLE;
			priority if (byte_in == BYTE_SPACE) begin
			end else if (byte_in == BYTE_SQ_LEAD) begin
				nx.mode = MODE_SQ_LEAD;
			end else if (is_digit(byte_in) || byte_in == BYTE_POINT) begin
				do_begin = 1'b1;
			end else if (byte_in == BYTE_MINUS && st_q.op_ctx) begin
				nx.mode = MODE_MINUS;
			end else if (is_alpha(byte_in)) begin
				main_v = 1'b1;
				if (full) begin
					main_r.kind = KIND_ERROR;
					nx.mode = MODE_SKIP;
				end else begin
					main_r.kind = KIND_IDENT_CHAR;
					main_r.ch = to_lower(byte_in);
					nx.total = st_q.total + 1'b1;
					nx.len = LEN_BITS'(1);
					nx.op_ctx = 1'b0;
					nx.mode = MODE_IDENT;
				end
			end else if (is_op_byte(byte_in)) begin
				main_v = 1'b1;
				if (st_q.op_ctx || full) begin
					main_r.kind = KIND_ERROR;
					nx.mode = MODE_SKIP;
				end else begin
					main_r.kind = KIND_OPERATOR;
					main_r.op = op_of(byte_in);
					nx.total = st_q.total + 1'b1;
					nx.op_ctx = 1'b1;
				end
			end else if (byte_in == BYTE_LPAREN || byte_in == BYTE_RPAREN) begin
				main_v = 1'b1;
				if (full) begin
					main_r.kind = KIND_ERROR;
					nx.mode = MODE_SKIP;
				end else begin
					main_r.kind = (byte_in == BYTE_LPAREN) ? KIND_LPAREN : KIND_RPAREN;
					nx.total = st_q.total + 1'b1;
					nx.op_ctx = byte_in == BYTE_LPAREN;
				end
			end else begin
				main_v = 1'b1;
				main_r.kind = KIND_ERROR;
				nx.mode = MODE_SKIP;
			end
		end

		if (do_begin) begin
			if (full) begin
				main_v = 1'b1;
				main_r.kind = KIND_ERROR;
				nx.mode = MODE_SKIP;
			end else begin
				nx.total = st_q.total + 1'b1;
				nx.frac = '0;
				nx.clamp = 1'b0;
				nx.neg = begin_neg;
				nx.op_ctx = 1'b0;
				if (byte_in == BYTE_POINT) begin
					nx.acc = '0;
					nx.mode = MODE_FRAC;
				end else begin
					nx.acc = {{(MAG_BITS-4){1'b0}}, dig};
					nx.mode = MODE_INT;
				end
			end
		end

		main_r.tokens = end_mark ? st_q.total : nx.total;
	end

	assign push_n = {1'b0, pre_v} + {1'b0, main_v};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= clear_state();
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (in_acc) begin
				st_q <= nx;
				wptr_q <= wptr_q + PTR_BITS'(push_n);
			end
			if (out_acc) begin
				rptr_q <= rptr_q + 1'b1;
			end
			fill_q <= fill_q + (in_acc ? FILL_BITS'(push_n) : '0) - FILL_BITS'(out_acc);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (pre_v) begin
				fifo_q[wptr_q] <= '{res: pre_r, last: !main_v};
			end
			if (main_v) begin
				fifo_q[wptr_q + PTR_BITS'(pre_v)] <= '{res: main_r, last: 1'b1};
			end
		end
	end

	assign head = fifo_q[rptr_q];
	assign kind = head.res.kind;
	assign op_code = head.res.op;
	assign mantissa = $signed(head.res.mant);
	assign frac_count = head.res.frac;
	assign saturated = head.res.sat;
	assign ident_char = head.res.ch;
	assign tokens_seen = head.res.tokens;
	assign last = head.last;

	// The result queue never holds more entries than it has.
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_BITS'(FIFO_DEPTH))
		else $error("result queue overfilled");

	// A byte taken while skipping after an error produces no result.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !end_mark && st_q.mode == MODE_SKIP |-> push_n == 2'd0)
		else $error("result produced while skipping");

	// An end marker returns the lexer to the start of a new expression.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && end_mark |=> st_q.mode == MODE_IDLE && st_q.total == '0 && st_q.op_ctx)
		else $error("lexer not cleared after end marker");

	// The token count never passes its limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q.total <= TOKEN_LIMIT)
		else $error("token count above limit");

	// A transaction that leaves the queue empty cannot have pushed a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && push_n != 2'd0 |=> fill_q != '0)
		else $error("pushed result lost");

endmodule

// ----- bench/arith_expression_lexer_tb.sv -----
// Self-checking testbench for the arithmetic expression lexer: directed table, random expressions.
module arith_expression_lexer_tb import ael_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1100;
	localparam int PAUSE_AT = 300;
	localparam int HOLD_AT = 400;
	localparam int HOLD_CYCLES = 80;
	localparam int CALM_FROM = 700;
	localparam int CALM_TO = 900;
	localparam int STALL_LIMIT = 1000;
	localparam int TAIL_CYCLES = 20;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_ONE = 8'h31;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [63:0] MAG_LIMIT = 64'(MAG_MAX);

	typedef struct {
		logic [7:0] data;
		logic endm;
		logic typed;
		kind_t want_kind;
		logic [8:0] want_tokens;
	} stim_t;

	typedef struct {
		kind_t kind;
		op_t op;
		logic [47:0] mant;
		logic [3:0] frac;
		logic sat;
		logic [7:0] ch;
		logic [8:0] tokens;
		logic last;
	} token_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] byte_in = 8'h00;
	logic end_mark = 1'b0;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	logic [2:0] kind;
	logic [2:0] op_code;
	logic signed [47:0] mantissa;
	logic [3:0] frac_count;
	logic saturated;
	logic [7:0] ident_char;
	logic [8:0] tokens_seen;
	logic last;

	stim_t expr_bytes [$];
	token_t expected_tokens [$];
	int accepted_in = 0;
	int fail_cnt = 0;
	int quiet_cycles = 0;
	logic calm;

	mode_t lx_mode;
	logic lx_op_ctx;
	logic [8:0] lx_total;
	logic [63:0] lx_acc;
	logic [3:0] lx_frac;
	logic lx_neg;
	logic lx_clamp;
	logic [4:0] lx_len;

	logic [7:0] op_bytes [5] = '{BYTE_PLUS, BYTE_MINUS, BYTE_STAR, BYTE_SLASH, BYTE_CARET};

	stim_t directed_rows [27] = '{
		'{8'h00, 1'b1, 1'b1, KIND_DONE, 9'd0},
		'{BYTE_MINUS, 1'b0, 1'b0, KIND_NUMBER, 9'd0},
		'{8'h39, 1'b0, 1'b0, KIND_NUMBER, 9'd0},
		'{BYTE_MINUS, 1'b0, 1'b0, KIND_NUMBER, 9'd0},
		'{CH_UPPER_A, 1'b0, 1'b0, KIND_NUMBER, 9'd0},
		'{BYTE_UNDERSCORE, 1'b0, 1'b0, KIND_NUMBER, 9'd0},
		'{BYTE_SQ_LEAD, 1'b0, 1'b0, KIND_NUMBER, 9'd0},
		'{BYTE_SQ_TAIL, 1'b0, 1'b0, KIND_NUMBER, 9'd0},
		'{BYTE_STAR, 1'b0, 1'b0, KIND_NUMBER, 9'd0},
		'{BYTE_LPAREN, 1'b0, 1'b0, KIND_NUMBER, 9'd0},
		'{BYTE_POINT, 1'b0, 1'b0, KIND_NUMBER, 9'd0},
		'{8'h35, 1'b0, 1'b0, KIND_NUMBER, 9'd0},
		'{BYTE_POINT, 1'b0, 1'b0, KIND_NUMBER, 9'd0},
		'{BYTE_RPAREN, 1'b0, 1'b0, KIND_NUMBER, 9'd0},
		'{BYTE_CARET, 1'b0, 1'b0, KIND_NUMBER, 9'd0},
		'{8'h34, 1'b0, 1'b0, KIND_NUMBER, 9'd0},
		'{BYTE_SLASH, 1'b0, 1'b0, KIND_NUMBER, 9'd0},
		'{8'h32, 1'b0, 1'b0, KIND_NUMBER, 9'd0},
		'{BYTE_PLUS, 1'b0, 1'b0, KIND_NUMBER, 9'd0},
		'{BYTE_PLUS, 1'b0, 1'b1, KIND_ERROR, 9'd14},
		'{8'h00, 1'b1, 1'b0, KIND_NUMBER, 9'd0},
		'{8'hFF, 1'b0, 1'b1, KIND_ERROR, 9'd0},
		'{8'h00, 1'b1, 1'b0, KIND_NUMBER, 9'd0},
		'{BYTE_SQ_LEAD, 1'b0, 1'b0, KIND_NUMBER, 9'd0},
		'{8'hFF, 1'b1, 1'b1, KIND_ERROR, 9'd0},
		'{BYTE_MINUS, 1'b0, 1'b0, KIND_NUMBER, 9'd0},
		'{8'h00, 1'b1, 1'b1, KIND_ERROR, 9'd0}
	};

	arith_expression_lexer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_in(byte_in),
		.end_mark(end_mark),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.op_code(op_code),
		.mantissa(mantissa),
		.frac_count(frac_count),
		.saturated(saturated),
		.ident_char(ident_char),
		.tokens_seen(tokens_seen),
		.last(last)
	);

	assign calm = (accepted_in >= CALM_FROM) && (accepted_in < CALM_TO);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic is_digit_byte(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_ZERO + 8'd9);
	endfunction

	function automatic logic is_upper_byte(input logic [7:0] b);
		return (b >= CH_UPPER_A) && (b <= CH_UPPER_A + 8'd25);
	endfunction

	function automatic logic is_letter_byte(input logic [7:0] b);
		return is_upper_byte(b) || ((b >= CH_LOWER_A) && (b <= CH_LOWER_A + 8'd25));
	endfunction

	function automatic logic [7:0] fold_case(input logic [7:0] b);
		return is_upper_byte(b) ? b + 8'd32 : b;
	endfunction

	function automatic void reset_lexer();
		lx_mode = MODE_IDLE;
		lx_op_ctx = 1'b1;
		lx_total = '0;
		lx_acc = '0;
		lx_frac = '0;
		lx_neg = 1'b0;
		lx_clamp = 1'b0;
		lx_len = '0;
	endfunction

	function automatic void emit_token(input kind_t k, input op_t o, input logic [47:0] m,
			input logic [3:0] f, input logic s, input logic [7:0] c);
		expected_tokens.push_back('{k, o, m, f, s, c, lx_total, 1'b0});
	endfunction

	function automatic void raise_error();
		emit_token(KIND_ERROR, OP_PLUS, '0, '0, 1'b0, '0);
		lx_mode = MODE_SKIP;
	endfunction

	function automatic logic claim_token();
		if (lx_total >= TOKEN_LIMIT) begin
			raise_error();
			return 1'b0;
		end
		lx_total = lx_total + 9'd1;
		return 1'b1;
	endfunction

	function automatic void push_int_digit(input logic [63:0] d);
		if (lx_acc > (MAG_LIMIT - d) / 64'd10) begin
			lx_acc = MAG_LIMIT;
			lx_clamp = 1'b1;
		end else begin
			lx_acc = lx_acc * 64'd10 + d;
		end
	endfunction

	function automatic void push_frac_digit(input logic [63:0] d);
		if (lx_frac < FRACTION_DIGIT_LIMIT && lx_acc <= (MAG_LIMIT - d) / 64'd10) begin
			lx_acc = lx_acc * 64'd10 + d;
			lx_frac = lx_frac + 4'd1;
		end else begin
			lx_mode = MODE_FRAC_DROP;
		end
	endfunction

	function automatic void open_number(input logic neg, input logic [7:0] b);
		if (!claim_token())
			return;
		lx_acc = '0;
		lx_frac = '0;
		lx_clamp = 1'b0;
		lx_neg = neg;
		lx_op_ctx = 1'b0;
		if (b == BYTE_POINT) begin
			lx_mode = MODE_FRAC;
		end else begin
			lx_mode = MODE_INT;
			push_int_digit(64'(b - CH_ZERO));
		end
	endfunction

	function automatic void flush_number();
		logic [63:0] m;
		m = lx_neg ? (64'd0 - lx_acc) : lx_acc;
		emit_token(KIND_NUMBER, OP_PLUS, m[47:0], lx_frac, lx_clamp, '0);
		lx_mode = MODE_IDLE;
	endfunction

	function automatic void lex_start(input logic [7:0] b);
		op_t o;
		logic is_op;
		lx_mode = MODE_IDLE;
		is_op = 1'b1;
		o = OP_PLUS;
		case (b)
			BYTE_PLUS: o = OP_PLUS;
			BYTE_MINUS: o = OP_MINUS;
			BYTE_STAR: o = OP_TIMES;
			BYTE_SLASH: o = OP_DIVIDE;
			BYTE_CARET: o = OP_POWER;
			default: is_op = 1'b0;
		endcase
		if (b == BYTE_SPACE)
			return;
		if (b == BYTE_SQ_LEAD) begin
			lx_mode = MODE_SQ_LEAD;
			return;
		end
		if (is_digit_byte(b) || b == BYTE_POINT) begin
			open_number(1'b0, b);
			return;
		end
		if (b == BYTE_MINUS && lx_op_ctx) begin
			lx_mode = MODE_MINUS;
			return;
		end
		if (is_letter_byte(b)) begin
			if (!claim_token())
				return;
			emit_token(KIND_IDENT_CHAR, OP_PLUS, '0, '0, 1'b0, fold_case(b));
			lx_len = 5'd1;
			lx_op_ctx = 1'b0;
			lx_mode = MODE_IDENT;
			return;
		end
		if (is_op) begin
			if (lx_op_ctx) begin
				raise_error();
				return;
			end
			if (!claim_token())
				return;
			emit_token(KIND_OPERATOR, o, '0, '0, 1'b0, '0);
			lx_op_ctx = 1'b1;
			return;
		end
		if (b == BYTE_LPAREN || b == BYTE_RPAREN) begin
			if (!claim_token())
				return;
			emit_token((b == BYTE_LPAREN) ? KIND_LPAREN : KIND_RPAREN, OP_PLUS, '0, '0, 1'b0, '0);
			lx_op_ctx = (b == BYTE_LPAREN);
			return;
		end
		raise_error();
	endfunction

	function automatic void lex_byte(input logic [7:0] b);
		case (lx_mode)
			MODE_SKIP: ;
			MODE_MINUS: begin
				if (is_digit_byte(b) || b == BYTE_POINT)
					open_number(1'b1, b);
				else
					raise_error();
			end
			MODE_SQ_LEAD: begin
				if (b != BYTE_SQ_TAIL) begin
					raise_error();
				end else begin
					lx_mode = MODE_IDLE;
					if (claim_token()) begin
						emit_token(KIND_OPERATOR, OP_SQUARE, '0, '0, 1'b0, '0);
						lx_op_ctx = 1'b0;
					end
				end
			end
			MODE_INT: begin
				if (is_digit_byte(b)) begin
					push_int_digit(64'(b - CH_ZERO));
				end else if (b == BYTE_POINT) begin
					lx_mode = lx_clamp ? MODE_FRAC_DROP : MODE_FRAC;
				end else begin
					flush_number();
					lex_start(b);
				end
			end
			MODE_FRAC: begin
				if (is_digit_byte(b)) begin
					push_frac_digit(64'(b - CH_ZERO));
				end else begin
					flush_number();
					lex_start(b);
				end
			end
			MODE_FRAC_DROP: begin
				if (!is_digit_byte(b)) begin
					flush_number();
					lex_start(b);
				end
			end
			MODE_IDENT: begin
				if (is_letter_byte(b) || is_digit_byte(b) || b == BYTE_UNDERSCORE) begin
					if (lx_len < NAME_CHAR_LIMIT) begin
						emit_token(KIND_IDENT_CHAR, OP_PLUS, '0, '0, 1'b0, fold_case(b));
						lx_len = lx_len + 5'd1;
					end
				end else begin
					emit_token(KIND_IDENT_END, OP_PLUS, '0, '0, 1'b0, '0);
					lex_start(b);
				end
			end
			default: lex_start(b);
		endcase
	endfunction

	function automatic void lex_end();
		case (lx_mode)
			MODE_SKIP: ;
			MODE_MINUS, MODE_SQ_LEAD: raise_error();
			MODE_INT, MODE_FRAC, MODE_FRAC_DROP: begin
				flush_number();
				emit_token(KIND_DONE, OP_PLUS, '0, '0, 1'b0, '0);
			end
			MODE_IDENT: begin
				emit_token(KIND_IDENT_END, OP_PLUS, '0, '0, 1'b0, '0);
				emit_token(KIND_DONE, OP_PLUS, '0, '0, 1'b0, '0);
			end
			default: emit_token(KIND_DONE, OP_PLUS, '0, '0, 1'b0, '0);
		endcase
		reset_lexer();
	endfunction

	function automatic void check_field(input string name, input logic [47:0] want,
			input logic [47:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_cnt++;
		end
	endfunction

	function automatic logic [7:0] name_char();
		int r;
		r = $urandom_range(0, 62);
		if (r < 26)
			return CH_UPPER_A + 8'(r);
		if (r < 52)
			return CH_LOWER_A + 8'(r - 26);
		if (r < 62)
			return CH_ZERO + 8'(r - 52);
		return BYTE_UNDERSCORE;
	endfunction

	function automatic void add_byte(input logic [7:0] b, input logic endm);
		expr_bytes.push_back('{b, endm, 1'b0, KIND_NUMBER, 9'd0});
	endfunction

	task automatic gen_operand(ref logic [7:0] q [$], input int depth);
		int pick;
		int nint;
		int nfrac;
		pick = $urandom_range(0, 99);
		if (pick < 15 && depth < 2) begin
			q.push_back(BYTE_LPAREN);
			gen_sum(q, depth + 1);
			q.push_back(BYTE_RPAREN);
		end else if (pick < 50) begin
			nint = ($urandom_range(0, 9) == 0) ? $urandom_range(27, 33) : $urandom_range(1, 6);
			q.push_back(($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'($urandom_range(0, 25)));
			repeat (nint - 1) q.push_back(name_char());
		end else begin
			if ($urandom_range(0, 3) == 0)
				q.push_back(BYTE_MINUS);
			nint = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 22) : $urandom_range(0, 4);
			nfrac = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 3);
			repeat (nint) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			if (nint == 0 || $urandom_range(0, 2) == 0) begin
				q.push_back(BYTE_POINT);
				repeat (nfrac) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			end
		end
		if ($urandom_range(0, 6) == 0) begin
			q.push_back(BYTE_SQ_LEAD);
			q.push_back(BYTE_SQ_TAIL);
		end
	endtask

	task automatic gen_sum(ref logic [7:0] q [$], input int depth);
		int n;
		n = $urandom_range(1, 5);
		for (int i = 0; i < n; i++) begin
			if (i > 0) begin
				q.push_back(op_bytes[$urandom_range(0, 4)]);
				if ($urandom_range(0, 5) == 0)
					q.push_back(BYTE_SPACE);
			end
			gen_operand(q, depth);
			if ($urandom_range(0, 5) == 0)
				q.push_back(BYTE_SPACE);
		end
	endtask

	always @(posedge clk) begin : scoreboard
		token_t want;
		int n0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				n0 = expected_tokens.size();
				if (end_mark)
					lex_end();
				else
					lex_byte(byte_in);
				if (expr_bytes[accepted_in].typed) begin
					while (expected_tokens.size() > n0)
						void'(expected_tokens.pop_back());
					expected_tokens.push_back('{expr_bytes[accepted_in].want_kind, OP_PLUS, '0, '0,
						1'b0, '0, expr_bytes[accepted_in].want_tokens, 1'b1});
				end else if (expected_tokens.size() > n0) begin
					expected_tokens[expected_tokens.size() - 1].last = 1'b1;
				end
				accepted_in++;
			end
			if (out_valid && !out_stall) begin
				if (expected_tokens.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, actual kind %0d",
						$time, kind);
					fail_cnt++;
				end else begin
					want = expected_tokens.pop_front();
					check_field("kind", 48'(want.kind), 48'(kind));
					check_field("op_code", 48'(want.op), 48'(op_code));
					check_field("mantissa", want.mant, 48'(mantissa));
					check_field("frac_count", 48'(want.frac), 48'(frac_count));
					check_field("saturated", 48'(want.sat), 48'(saturated));
					check_field("ident_char", 48'(want.ch), 48'(ident_char));
					check_field("tokens_seen", 48'(want.tokens), 48'(tokens_seen));
					check_field("last", 48'(want.last), 48'(last));
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("arith_expression_lexer_tb failed");
				$finish;
			end
		end
	end

	initial begin : result_pace
		logic held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && accepted_in >= HOLD_AT) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= !calm && ($urandom_range(0, 99) < 31);
		end
	end

	initial begin : feeder
		logic [7:0] body [$];
		int pick;
		int parens;
		logic limit_done;
		limit_done = 1'b0;
		reset_lexer();
		foreach (directed_rows[k])
			expr_bytes.push_back(directed_rows[k]);
		while (expr_bytes.size() < $size(directed_rows) + RANDOM_ITEMS) begin
			body.delete();
			pick = $urandom_range(0, 99);
			if (!limit_done && expr_bytes.size() > 700) begin
				limit_done = 1'b1;
				parens = $urandom_range(254, 256);
				repeat (parens) body.push_back(BYTE_LPAREN);
				body.push_back(CH_ONE);
				body.push_back(BYTE_PLUS);
				body.push_back(CH_ONE);
			end else if (pick < 12) begin
				repeat ($urandom_range(0, 8)) body.push_back(8'($urandom_range(0, 255)));
			end else begin
				gen_sum(body, 0);
				if (pick < 24)
					body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(0, 255));
				else if (pick < 30)
					body.push_back($urandom_range(0, 1) ? BYTE_MINUS : BYTE_SQ_LEAD);
			end
			foreach (body[k])
				add_byte(body[k], 1'b0);
			add_byte(8'($urandom_range(0, 255)), 1'b1);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < expr_bytes.size(); i++) begin
			while (!calm && $urandom_range(0, 99) < 31) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			if (i == PAUSE_AT) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (expected_tokens.size() != 0) @(posedge clk);
			end
			in_valid <= 1'b1;
			byte_in <= expr_bytes[i].data;
			end_mark <= expr_bytes[i].endm;
			@(posedge clk);
			while (in_stall) @(posedge clk);
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("arith_expression_lexer_tb passed");
		else
			$display("arith_expression_lexer_tb failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/ael_pkg.sv
rtl/core/arith_expression_lexer.sv
bench/arith_expression_lexer_tb.sv
